// ===== rtl/klru_pkg.sv =====
// Shared types, codes and defaults for the k-bucket LRU table.
`timescale 1ns / 1ps

package klru_pkg;

   localparam int DEF_MAX_ENTRIES = 16;
   localparam int DEF_KEY_BITS    = 64;

   localparam int KEY_PORT_W = 64;
   localparam int POS_PORT_W = 4;
   localparam int FILL_W     = 5;
   localparam int CAP_W      = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [2:0] {
      OP_LOOKUP     = 3'd0,
      OP_INSERT     = 3'd1,
      OP_TOUCH      = 3'd2,
      OP_REMOVE     = 3'd3,
      OP_FIRST_IDLE = 3'd4,
      OP_READ       = 3'd5,
      OP_SET_MARK   = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      STATUS_OK     = 3'd0,
      STATUS_FULL   = 3'd1,
      STATUS_ABSENT = 3'd2,
      STATUS_DUP    = 3'd3,
      STATUS_RANGE  = 3'd4
   } status_type;

   // Compare results that each cell captures for the update cycle.
   typedef struct packed {
      logic match;
      logic idle;
   } cell_flags_type;

   // Per-cell update command for the update cycle.
   typedef struct packed {
      logic shift;
      logic load;
      logic set_mark;
      logic new_mark;
   } cell_ctl_type;

endpackage

// ===== rtl/klru_cell.sv =====
// One list entry: key and ping mark, a key comparator and a shift link to its neighbor.
`timescale 1ns / 1ps

module klru_cell
   import klru_pkg::*;
#(
   parameter int KEY_BITS = DEF_KEY_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmp_en,
   input  logic                occupied,
   input  logic [KEY_BITS-1:0] cmp_key,
   input  cell_ctl_type        ctl,
   input  logic [KEY_BITS-1:0] new_key,
   input  logic [KEY_BITS-1:0] nb_key,
   input  logic                nb_mark,
   output logic [KEY_BITS-1:0] key_q,
   output logic                mark_q,
   output cell_flags_type      flags_q
);

   logic [KEY_BITS-1:0] key_ff;
   logic                mark_ff;
   cell_flags_type      flags_ff;

   // Keys hold no reset value; only occupied cells are ever read.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         key_ff <= new_key;
      end else if (ctl.shift) begin
         key_ff <= nb_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff  <= 1'b0;
         flags_ff <= '0;
      end else begin
         if (ctl.load || ctl.set_mark) begin
            mark_ff <= ctl.new_mark;
         end else if (ctl.shift) begin
            mark_ff <= nb_mark;
         end
         if (cmp_en) begin
            flags_ff.match <= occupied && (key_ff == cmp_key);
            flags_ff.idle  <= occupied && !mark_ff;
         end
      end
   end

   assign key_q   = key_ff;
   assign mark_q  = mark_ff;
   assign flags_q = flags_ff;

endmodule

// ===== rtl/kbucket_lru_table_unit.sv =====
// Top level of the k-bucket LRU table: request latch, control sequencer and the chain of cells.
`timescale 1ns / 1ps

// Usage. A request (req_op, req_key, req_position, req_ping_mark) is taken at a rising
// edge where start is high and busy is low. Every request gives exactly one response,
// shown on the rsp_ ports for one cycle with rsp_valid high; the receiver cannot stall,
// so it must sample the response in that cycle.
// Timing. A request is accepted, the next cycle every cell compares its key with the
// request key in parallel and records the match and idle flags, and the cycle after
// that the sequencer picks the position, drives the shift and load commands down the
// chain of cells and registers the response. busy is high only during the compare
// cycle, so a new request may be accepted in the update cycle.
// Configuration. csr_we with csr_wdata writes the capacity (k); write it only while
// no request is in flight. Zero acts as one, values above MAX_ENTRIES as MAX_ENTRIES.
// Reset. The list empties, all ping marks clear and the capacity returns to sixteen.
module kbucket_lru_table_unit
   import klru_pkg::*;
#(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   parameter int KEY_BITS    = DEF_KEY_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [2:0]            req_op,
   input  logic [KEY_PORT_W-1:0] req_key,
   input  logic [POS_PORT_W-1:0] req_position,
   input  logic                  req_ping_mark,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_status,
   output logic [KEY_PORT_W-1:0] rsp_found_key,
   output logic [POS_PORT_W-1:0] rsp_found_position,
   output logic                  rsp_found_mark,
   output logic [FILL_W-1:0]     rsp_fill,
   input  logic                  csr_we,
   input  logic [CAP_W-1:0]      csr_wdata
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CMP  = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [CAP_W-1:0]      cap_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   op_type                op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [POS_PORT_W-1:0] pos_ff;
   logic                  mark_ff;

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff, rsp_status_in;
   logic [KEY_PORT_W-1:0] rsp_key_ff, rsp_key_in;
   logic [POS_PORT_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic                  rsp_mark_ff, rsp_mark_in;
   logic [FILL_W-1:0]     rsp_fill_ff;

   logic                  accept;
   logic                  exec;

   // Chain signals.
   logic [KEY_BITS-1:0]   cell_key   [MAX_ENTRIES];
   logic                  cell_mark  [MAX_ENTRIES];
   cell_flags_type        cell_flags [MAX_ENTRIES];
   cell_ctl_type          cell_ctl   [MAX_ENTRIES];
   logic [KEY_BITS-1:0]   new_key;
   logic [MAX_ENTRIES-1:0] match_vec, idle_vec, match_oh, idle_oh;
   logic [IDX_W-1:0]      match_idx, idle_idx, sel_idx, tgt_idx, tail_idx;
   logic                  any_match, any_idle;
   logic [KEY_BITS-1:0]   sel_key;
   logic                  sel_mark;
   logic                  full;
   logic                  in_range;

   // Update-cycle commands decoded from the operation.
   logic                  do_insert, do_touch, do_remove, do_set;

   assign busy   = (state_ff == ST_CMP);
   assign accept = start && !busy;
   assign exec   = (state_ff == ST_EXEC);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_CMP;
         ST_CMP:  state_in = ST_EXEC;
         ST_EXEC: state_in = accept ? ST_CMP : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= exec;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         if (exec) begin
            count_ff <= count_in;
         end
      end
   end

   // Request latch; the update cycle reads the old contents at the same edge
   // at which a following request is taken.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_type'(req_op);
         key_ff  <= req_key[KEY_BITS-1:0];
         pos_ff  <= req_position;
         mark_ff <= req_ping_mark;
      end
   end

   // Response registers.
   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_status_ff <= rsp_status_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_mark_ff   <= rsp_mark_in;
         rsp_fill_ff   <= FILL_W'(count_in);
      end
   end

   // Lowest set flag wins: isolate it, then encode the one-hot word.
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match_vec[i] = cell_flags[i].match;
         idle_vec[i]  = cell_flags[i].idle;
      end
      match_oh  = match_vec & (~match_vec + MAX_ENTRIES'(1));
      idle_oh   = idle_vec & (~idle_vec + MAX_ENTRIES'(1));
      match_idx = '0;
      idle_idx  = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (match_oh[i]) match_idx = match_idx | IDX_W'(i);
         if (idle_oh[i])  idle_idx  = idle_idx | IDX_W'(i);
      end
      any_match = |match_vec;
      any_idle  = |idle_vec;
   end

   // The list is full at the smaller of the table depth and the capacity,
   // a capacity of zero counting as one.
   assign full = (count_ff >= CNT_MAX) ||
                 ((cap_ff == '0) ? (count_ff != '0)
                                 : (CMP_W'(count_ff) >= CMP_W'(cap_ff)));
   assign in_range = (CMP_W'(pos_ff) < CMP_W'(count_ff));
   assign tail_idx = IDX_W'(count_ff - CNT_W'(1));

   always_comb begin
      case (op_ff)
         OP_FIRST_IDLE: sel_idx = idle_idx;
         OP_READ:       sel_idx = IDX_W'(pos_ff);
         default:       sel_idx = match_idx;
      endcase
   end

   assign sel_key  = cell_key[sel_idx];
   assign sel_mark = cell_mark[sel_idx];

   always_comb begin
      rsp_status_in = STATUS_OK;
      rsp_key_in    = '0;
      rsp_pos_in    = '0;
      rsp_mark_in   = 1'b0;
      count_in      = count_ff;
      do_insert     = 1'b0;
      do_touch      = 1'b0;
      do_remove     = 1'b0;
      do_set        = 1'b0;
      tgt_idx       = match_idx;
      new_key       = key_ff;
      unique case (op_ff) inside
         OP_LOOKUP, OP_FIRST_IDLE: begin
            if ((op_ff == OP_LOOKUP) ? any_match : any_idle) begin
               rsp_key_in  = KEY_PORT_W'(sel_key);
               rsp_pos_in  = POS_PORT_W'(sel_idx);
               rsp_mark_in = sel_mark;
            end else begin
               rsp_status_in = STATUS_ABSENT;
            end
         end
         OP_INSERT: begin
            // A duplicate is reported before fullness.
            if (any_match) begin
               rsp_status_in = STATUS_DUP;
            end else if (full) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               do_insert  = 1'b1;
               tgt_idx    = IDX_W'(count_ff);
               rsp_key_in = KEY_PORT_W'(key_ff);
               rsp_pos_in = POS_PORT_W'(count_ff);
               count_in   = count_ff + CNT_W'(1);
            end
         end
         OP_TOUCH: begin
            if (any_match) begin
               do_touch    = 1'b1;
               rsp_key_in  = KEY_PORT_W'(key_ff);
               rsp_pos_in  = POS_PORT_W'(tail_idx);
               rsp_mark_in = sel_mark;
            end else begin
               rsp_status_in = STATUS_ABSENT;
            end
         end
         OP_REMOVE: begin
            if (any_match) begin
               do_remove   = 1'b1;
               rsp_key_in  = KEY_PORT_W'(key_ff);
               rsp_pos_in  = POS_PORT_W'(match_idx);
               rsp_mark_in = sel_mark;
               count_in    = count_ff - CNT_W'(1);
            end else begin
               rsp_status_in = STATUS_ABSENT;
            end
         end
         OP_READ: begin
            if (in_range) begin
               rsp_key_in  = KEY_PORT_W'(sel_key);
               rsp_pos_in  = POS_PORT_W'(sel_idx);
               rsp_mark_in = sel_mark;
            end else begin
               rsp_status_in = STATUS_RANGE;
            end
         end
         OP_SET_MARK: begin
            if (any_match) begin
               do_set      = 1'b1;
               rsp_key_in  = KEY_PORT_W'(sel_key);
               rsp_pos_in  = POS_PORT_W'(match_idx);
               rsp_mark_in = mark_ff;
            end else begin
               rsp_status_in = STATUS_ABSENT;
            end
         end
         default: begin
            // An unused code changes nothing and reports ok with empty fields.
         end
      endcase
   end

   // Per-cell commands. Touch and remove close the gap left at the matched
   // position by shifting the younger cells down one place; touch then loads
   // the key back in at the tail with its old mark.
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         cell_ctl[i] = '0;
         if (exec) begin
            if ((do_touch || do_remove) && (IDX_W'(i) >= match_idx) &&
                (CNT_W'(i) + CNT_W'(1) < count_ff)) begin
               cell_ctl[i].shift = 1'b1;
            end
            if (do_insert && (IDX_W'(i) == tgt_idx)) begin
               cell_ctl[i].load     = 1'b1;
               cell_ctl[i].new_mark = 1'b0;
            end
            if (do_touch && (IDX_W'(i) == tail_idx)) begin
               cell_ctl[i].load     = 1'b1;
               cell_ctl[i].new_mark = sel_mark;
            end
            if (do_set && (IDX_W'(i) == match_idx)) begin
               cell_ctl[i].set_mark = 1'b1;
               cell_ctl[i].new_mark = mark_ff;
            end
         end
      end
   end

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      logic [KEY_BITS-1:0] nb_key;
      logic                nb_mark;
      logic                occupied;

      if (g == MAX_ENTRIES - 1) begin : g_end
         assign nb_key  = '0;
         assign nb_mark = 1'b0;
      end else begin : g_link
         assign nb_key  = cell_key[g+1];
         assign nb_mark = cell_mark[g+1];
      end

      assign occupied = (CNT_W'(g) < count_ff);

      klru_cell #(
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmp_en   (busy),
         .occupied (occupied),
         .cmp_key  (key_ff),
         .ctl      (cell_ctl[g]),
         .new_key  (new_key),
         .nb_key   (nb_key),
         .nb_mark  (nb_mark),
         .key_q    (cell_key[g]),
         .mark_q   (cell_mark[g]),
         .flags_q  (cell_flags[g])
      );
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_key      = rsp_key_ff;
   assign rsp_found_position = rsp_pos_ff;
   assign rsp_found_mark     = rsp_mark_ff;
   assign rsp_fill           = rsp_fill_ff;

endmodule
